### rtl/fwbcs_pkg.sv
// Package: types, codes and ring arithmetic shared by the FIFO write-back cache store.
package fwbcs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = 5;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int CMD_W = 2;
    localparam int STAT_W = 3;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    localparam logic [STAT_W-1:0] ST_READ_HIT = 3'd0;
    localparam logic [STAT_W-1:0] ST_READ_MISS = 3'd1;
    localparam logic [STAT_W-1:0] ST_STORED = 3'd2;
    localparam logic [STAT_W-1:0] ST_STORED_EVICT = 3'd3;
    localparam logic [STAT_W-1:0] ST_WRITE_HIT = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_data;
        logic [ADDR_W-1:0] victim_address;
        logic [DATA_W-1:0] victim_data;
        logic victim_clean;
    } t_out;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic fetch;
        logic commit;
    } t_ctrl;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
        logic [SLOT_W-1:0] r;
        if (a == SLOT_W'(MAX_ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W+SLOT_W-1:0] s;
        s = (CNT_W+SLOT_W)'(a) + (CNT_W+SLOT_W)'(b);
        if (s >= (CNT_W+SLOT_W)'(MAX_ENTRIES)) begin
            s = s - (CNT_W+SLOT_W)'(MAX_ENTRIES);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] slot_offset(input logic [SLOT_W-1:0] s,
                                                     input logic [SLOT_W-1:0] base);
        logic [CNT_W+SLOT_W-1:0] d;
        if (s >= base) begin
            d = (CNT_W+SLOT_W)'(s) - (CNT_W+SLOT_W)'(base);
        end else begin
            d = (CNT_W+SLOT_W)'(s) + (CNT_W+SLOT_W)'(MAX_ENTRIES) - (CNT_W+SLOT_W)'(base);
        end
        return d[CNT_W-1:0];
    endfunction

endpackage

### rtl/fwbcs_ctrl.sv
// Controller: sequences capture, lookup, fetch and commit for each beat.
module fwbcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output fwbcs_pkg::t_ctrl    o_ctrl
);
    import fwbcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_FETCH,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic r_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;
    assign o_ctrl.capture = (r_state == S_IDLE) && i_start;
    assign o_ctrl.lookup = (r_state == S_LOOK);
    assign o_ctrl.fetch = (r_state == S_FETCH);
    assign o_ctrl.commit = (r_state == S_DONE);

endmodule

### rtl/fwbcs_dp.sv
// Datapath: entry store, associative compare, ring pointers and result register.
module fwbcs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fwbcs_pkg::t_ctrl                i_ctrl,
    input  fwbcs_pkg::t_in                  i_req,
    input  logic                            i_cfg_we,
    input  logic [fwbcs_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                            o_done,
    output fwbcs_pkg::t_out                 o_rsp
);
    import fwbcs_pkg::*;

    logic [ADDR_W-1:0] r_addr [MAX_ENTRIES];
    logic              r_clean [MAX_ENTRIES];
    logic [DATA_W-1:0] r_value [MAX_ENTRIES];

    t_in               r_in;
    logic [CAP_W-1:0]  r_cap;
    logic [SLOT_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_count;
    logic              r_hit;
    logic              r_evict;
    logic [SLOT_W-1:0] r_hit_slot;
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_vaddr;
    logic              r_vclean;
    logic              r_done;
    t_out              r_rsp;
    t_out              n_rsp;

    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [CMP_W-1:0]  eff_cap;
    logic              is_store;
    logic              is_put;
    logic              evict;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_slot;

    always_comb begin
        hit = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((slot_offset(SLOT_W'(i), r_oldest) < r_count) &&
                (r_addr[i] == r_in.address)) begin
                hit = 1'b1;
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    assign is_put = (r_in.command == CMD_PUT);
    assign is_store = is_put || (r_in.command == CMD_WRITE);
    assign evict = is_store && !hit && (CMP_W'(r_count) >= eff_cap) && (r_count != '0);
    assign new_slot = slot_add(r_oldest, r_count);
    assign wr_slot = r_hit ? r_hit_slot : new_slot;
    assign wr_en = i_ctrl.commit && is_store;
    assign rd_slot = r_hit ? r_hit_slot : r_oldest;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_value[wr_slot] <= r_in.write_data;
        end
        if (i_ctrl.fetch) begin
            r_rd_data <= r_value[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_in <= i_req;
        end
        if (i_ctrl.lookup) begin
            r_hit <= hit;
            r_hit_slot <= hit_slot;
            r_evict <= evict;
        end
        if (i_ctrl.fetch) begin
            r_vaddr <= r_addr[r_oldest];
            r_vclean <= r_clean[r_oldest];
        end
        if (wr_en) begin
            r_clean[wr_slot] <= is_put;
            if (!r_hit) begin
                r_addr[wr_slot] <= r_in.address;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_oldest <= '0;
            r_count <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_done <= i_ctrl.commit;
            if (wr_en && !r_hit) begin
                if (r_evict) begin
                    r_oldest <= slot_inc(r_oldest);
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_rsp = '0;
        if (is_store) begin
            if (r_hit) begin
                if (is_put) begin
                    n_rsp.status = ST_STORED;
                end else begin
                    n_rsp.status = ST_WRITE_HIT;
                    n_rsp.read_data = r_in.write_data;
                end
            end else if (r_evict) begin
                n_rsp.status = ST_STORED_EVICT;
                n_rsp.victim_address = r_vaddr;
                n_rsp.victim_data = r_rd_data;
                n_rsp.victim_clean = r_vclean;
            end else begin
                n_rsp.status = ST_STORED;
            end
        end else if (r_hit) begin
            n_rsp.status = ST_READ_HIT;
            n_rsp.read_data = r_rd_data;
        end else begin
            n_rsp.status = ST_READ_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds the store depth");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_STORED_EVICT)) |-> (r_count == $past(r_count)))
        else $error("eviction changed the entry count");

    a_evict_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_STORED_EVICT)) |-> (r_oldest == slot_inc($past(r_oldest))))
        else $error("eviction did not advance the oldest slot");

endmodule

### rtl/fifo_write_back_cache_store_core.sv
// Top level: FIFO-replacement fully associative write-back cache store.
//
// Channel   Direction  Handshake                 Payload
// request   in         i_start high, o_busy low  i_req (t_in)
// response  out        o_done one-cycle strobe   o_rsp (t_out)
// config    in         i_cfg_we                  i_cfg_wdata (capacity)
//
// Each beat passes through capture, associative lookup, entry memory read and commit in turn.
// The response strobe follows the commit cycle, while a new beat may already be taken.
// Reset empties the store and sets the capacity to sixteen; no clearing pass is needed.
// The receiver cannot stall; every response is presented for exactly one cycle.
module fifo_write_back_cache_store_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  fwbcs_pkg::t_in                  i_req,
    output logic                            o_done,
    output fwbcs_pkg::t_out                 o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fwbcs_pkg::CAP_W-1:0]     i_cfg_wdata
);
    import fwbcs_pkg::*;

    t_ctrl ctrl;

    fwbcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_ctrl  (ctrl)
    );

    fwbcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
